/* sv/hlvn_pkg.sv */
`timescale 1ns / 1ps
// Constants for the hash lattice value noise block: lattice primes, the hash
// finaliser constants and the fixed point format. Depends on nothing.

package hlvn_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int FADE_BITS         = 16;

	localparam logic [31:0] PRIME_X   = 32'd73856093;
	localparam logic [31:0] PRIME_Y   = 32'd19349663;
	localparam logic [31:0] PRIME_Z   = 32'd83492791;
	localparam logic [31:0] MIX_MULT  = 32'd1274126177;
	localparam int          SHIFT_A   = 13;
	localparam int          SHIFT_B   = 16;

	localparam logic [23:0] FULL24    = 24'hffffff;
	localparam logic [17:0] FADE_K3   = 18'd196608;
	localparam logic [49:0] FADE_RND  = 50'h0_8000_0000;
	localparam int          FADE_SH   = 32;
	localparam int          OUT_SH    = 47;

endpackage

/* sv/hash_lattice_value_noise_3d.sv */
`timescale 1ns / 1ps
// 3D value noise over a hashed integer lattice, smoothstep trilinear blend.
// Seven stage pipeline; depends on hlvn_pkg for constants.
//
//  channel | handshake          | word
//  --------+--------------------+--------------------------------------
//  in      | in_valid/in_stall  | x_coord, y_coord, z_coord (Q.FRACTION_BITS)
//  out     | out_valid/out_stall| noise_value (signed, 1/16777215 units)
//
// One point enters per cycle while in_stall is low; it then passes the seven register
// stages (prime products, corner xor and fade, finaliser multiply, blends along x, y
// and z, round) before out_valid rises. Reset clears only the valid bits.
// A stalled output holds its word; bubbles in the pipe still close up, and
// in_stall rises only once every stage holds a word.

module hash_lattice_value_noise_3d #(
	parameter int FRACTION_BITS = hlvn_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic signed [31:0] z_coord,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [24:0] noise_value
);

	localparam int FB        = FRACTION_BITS;
	localparam int FRAC_DOWN = (FB > hlvn_pkg::FADE_BITS) ? FB - hlvn_pkg::FADE_BITS : 0;
	localparam int FRAC_UP   = (FB < hlvn_pkg::FADE_BITS) ? hlvn_pkg::FADE_BITS - FB : 0;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	// advance chain
	always_comb begin
		adv7 = !out_valid || !out_stall;
		adv6 = !valid_s6 || adv7;
		adv5 = !valid_s5 || adv6;
		adv4 = !valid_s4 || adv5;
		adv3 = !valid_s3 || adv4;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
	end

	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv1) valid_s1  <= in_valid;
			if (adv2) valid_s2  <= valid_s1;
			if (adv3) valid_s3  <= valid_s2;
			if (adv4) valid_s4  <= valid_s3;
			if (adv5) valid_s5  <= valid_s4;
			if (adv6) valid_s6  <= valid_s5;
			if (adv7) out_valid <= valid_s6;
		end
	end

	// stage 1: cells, prime products, fraction squares
	logic [31:0] px_s1, py_s1, pz_s1;
	logic [15:0] fx_s1, fy_s1, fz_s1;
	logic [31:0] ffx_s1, ffy_s1, ffz_s1;
	logic [31:0] cx, cy, cz;
	logic [15:0] fx, fy, fz;
	logic [39:0] wx, wy, wz;

	always_comb begin
		cx = 32'(x_coord >>> FB);
		cy = 32'(y_coord >>> FB);
		cz = 32'(z_coord >>> FB);
		wx = {{(40 - FB){1'b0}}, x_coord[FB-1:0]};
		wy = {{(40 - FB){1'b0}}, y_coord[FB-1:0]};
		wz = {{(40 - FB){1'b0}}, z_coord[FB-1:0]};
		fx = 16'((wx >> FRAC_DOWN) << FRAC_UP);
		fy = 16'((wy >> FRAC_DOWN) << FRAC_UP);
		fz = 16'((wz >> FRAC_DOWN) << FRAC_UP);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			px_s1  <= 32'(cx * hlvn_pkg::PRIME_X);
			py_s1  <= 32'(cy * hlvn_pkg::PRIME_Y);
			pz_s1  <= 32'(cz * hlvn_pkg::PRIME_Z);
			fx_s1  <= fx;
			fy_s1  <= fy;
			fz_s1  <= fz;
			ffx_s1 <= 32'(fx * fx);
			ffy_s1 <= 32'(fy * fy);
			ffz_s1 <= 32'(fz * fz);
		end
	end

	// stage 2: corner xor and first xorshift, fade weights
	logic [31:0] g_s2 [8];
	logic [16:0] tx_s2, ty_s2, tz_s2;
	logic [31:0] g_n  [8];
	logic [31:0] h_n  [8];

	always_comb begin
		for (int c = 0; c < 8; c++) begin
			h_n[c] = (px_s1 + (((c & 1) != 0) ? hlvn_pkg::PRIME_X : 32'd0))
			       ^ (py_s1 + (((c & 2) != 0) ? hlvn_pkg::PRIME_Y : 32'd0))
			       ^ (pz_s1 + (((c & 4) != 0) ? hlvn_pkg::PRIME_Z : 32'd0));
			g_n[c] = h_n[c] ^ (h_n[c] >> hlvn_pkg::SHIFT_A);
		end
	end

	function automatic logic [16:0] fade(input logic [31:0] ff, input logic [15:0] f);
		logic [17:0] k;
		logic [49:0] p;
		begin
			k = hlvn_pkg::FADE_K3 - {1'b0, f, 1'b0};
			p = 50'(ff * k) + hlvn_pkg::FADE_RND;
			fade = 17'(p >> hlvn_pkg::FADE_SH);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int c = 0; c < 8; c++) g_s2[c] <= g_n[c];
			tx_s2 <= fade(ffx_s1, fx_s1);
			ty_s2 <= fade(ffy_s1, fy_s1);
			tz_s2 <= fade(ffz_s1, fz_s1);
		end
	end

	// stage 3: finaliser multiply
	logic [31:0] m_s3 [8];
	logic [16:0] tx_s3, ty_s3, tz_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int c = 0; c < 8; c++) m_s3[c] <= 32'(g_s2[c] * hlvn_pkg::MIX_MULT);
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;
			tz_s3 <= tz_s2;
		end
	end

	// stage 4: corner values, blend along x
	logic [23:0] v_n  [8];
	logic [39:0] a_n  [4];
	logic [39:0] a_s4 [4];
	logic [16:0] ty_s4, tz_s4;
	logic signed [24:0] dv;
	logic signed [41:0] la;

	always_comb begin
		for (int c = 0; c < 8; c++) v_n[c] = 24'(m_s3[c] ^ (m_s3[c] >> hlvn_pkg::SHIFT_B));
		dv = '0;
		la = '0;
		for (int j = 0; j < 4; j++) begin
			dv = $signed({1'b0, v_n[2*j+1]}) - $signed({1'b0, v_n[2*j]});
			la = $signed({2'b00, v_n[2*j], 16'h0000}) + 42'(dv * $signed({1'b0, tx_s3}));
			a_n[j] = la[39:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int j = 0; j < 4; j++) a_s4[j] <= a_n[j];
			ty_s4 <= ty_s3;
			tz_s4 <= tz_s3;
		end
	end

	// stage 5: blend along y
	logic [55:0] b_n  [2];
	logic [55:0] b_s5 [2];
	logic [16:0] tz_s5;
	logic signed [40:0] da;
	logic signed [58:0] lb;

	always_comb begin
		da = '0;
		lb = '0;
		for (int k = 0; k < 2; k++) begin
			da = $signed({1'b0, a_s4[2*k+1]}) - $signed({1'b0, a_s4[2*k]});
			lb = $signed({3'b000, a_s4[2*k], 16'h0000}) + 59'(da * $signed({1'b0, ty_s4}));
			b_n[k] = lb[55:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			b_s5[0] <= b_n[0];
			b_s5[1] <= b_n[1];
			tz_s5   <= tz_s4;
		end
	end

	// stage 6: blend along z
	logic [71:0] sum_s6;
	logic signed [56:0] db;
	logic signed [74:0] ls;

	always_comb begin
		db = $signed({1'b0, b_s5[1]}) - $signed({1'b0, b_s5[0]});
		ls = $signed({3'b000, b_s5[0], 16'h0000}) + 75'(db * $signed({1'b0, tz_s5}));
	end

	always_ff @(posedge clk) begin
		if (adv6) sum_s6 <= ls[71:0];
	end

	// stage 7: round to nearest, recentre
	logic [72:0] rnd;
	logic [24:0] lvl;

	always_comb begin
		rnd = {1'b0, sum_s6} + (73'd1 << (hlvn_pkg::OUT_SH - 1));
		lvl = rnd[hlvn_pkg::OUT_SH +: 25];
	end

	always_ff @(posedge clk) begin
		if (adv7) noise_value <= $signed(lvl - {1'b0, hlvn_pkg::FULL24});
	end

`ifndef ASSERT_OFF
	a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage empty");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled while first stage empty");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |->
		($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, out_valid})
		 + $past(out_valid && !out_stall)
		 == $past($countones({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6,
			out_valid})) + $past(in_valid && !in_stall)))
		else $error("word lost or duplicated in pipeline");
`endif

endmodule
